FILE: hdl/sjfs_pkg.sv
// ----------------------------------------------------------------------------
// SJF scheduler package
// Shared constants, command codes, queue entry types and cell control bundles.
// ----------------------------------------------------------------------------
package sjfs_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int FILL_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_ADMIT = 2'd1;
   localparam logic [1:0] CMD_BLOCK = 2'd2;
   localparam logic [1:0] CMD_NOP   = 2'd3;

   typedef logic [FILL_W-1:0] fill_type;

   typedef struct packed {
      logic [7:0]  pid;
      logic [15:0] burst;
   } ready_entry_type;

   typedef struct packed {
      logic [7:0]  pid;
      logic [15:0] burst;
      logic [15:0] io;
   } wait_entry_type;

   // broadcast to every ready cell
   typedef struct packed {
      logic            ins;
      logic            pop;
      ready_entry_type new_entry;
   } ready_ctrl_type;

   // broadcast to every waiting cell
   typedef struct packed {
      logic           ins;
      logic           pop;
      logic           dec;
      wait_entry_type new_entry;
   } wait_ctrl_type;

endpackage

FILE: hdl/sjf_ready_and_io_wait_scheduler.sv
// ----------------------------------------------------------------------------
// Shortest-job-first scheduler with I/O wait queue
// Two chains of cells hold a burst-sorted ready queue and an I/O-count-sorted
// waiting queue; commands admit, block and tick move processes between them.
// ----------------------------------------------------------------------------
//  channel  | handshake            | beat contents
//  ---------+----------------------+-------------------------------------------
//  request  | start, busy          | req_command, req_process_id,
//           |                      | req_burst_length, req_io_cycles
//  response | rsp_valid (strobe)   | rsp_head_valid, rsp_head_process_id,
//           |                      | rsp_head_burst, rsp_ready_count,
//           |                      | rsp_waiting_count, rsp_rejected
//
//  A request beat is taken when start is high and busy is low.
//  For admit, block and no-op the response strobe follows in the next cycle,
//  and a new request may be taken in that same cycle.
//  A tick moves the waiting-queue head to the ready queue one entry a cycle
//  while that head's count is zero, then decrements all counts; busy is high
//  until the decrement is done, and the response strobe follows it.
//  Synchronous reset empties both queues (fill counts only; slots stay as-is).
//  The response beat cannot be stalled; it is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module sjf_ready_and_io_wait_scheduler import sjfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_command,
   input  logic [7:0]  req_process_id,
   input  logic [15:0] req_burst_length,
   input  logic [15:0] req_io_cycles,
   output logic        rsp_valid,
   output logic        rsp_head_valid,
   output logic [7:0]  rsp_head_process_id,
   output logic [15:0] rsp_head_burst,
   output logic [4:0]  rsp_ready_count,
   output logic [4:0]  rsp_waiting_count,
   output logic        rsp_rejected
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_TICK = 1'b1;

   logic     state_ff, state_in;
   fill_type ready_fill_ff, ready_fill_in;
   fill_type waiting_fill_ff, waiting_fill_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     rej_ff, rej_in;

   ready_ctrl_type  r_ctrl;
   wait_ctrl_type   w_ctrl;
   ready_entry_type r_entry [QUEUE_DEPTH];
   logic            r_stays [QUEUE_DEPTH];
   logic            r_occ   [QUEUE_DEPTH];
   wait_entry_type  w_entry [QUEUE_DEPTH];
   logic            w_stays [QUEUE_DEPTH];
   logic            w_occ   [QUEUE_DEPTH];

   logic            accept;
   logic            admit_ok;
   logic            block_ok;
   logic            ready_full;
   logic            waiting_full;
   logic            wait_release;
   logic [FILL_W:0] fill_sum;

   // ---------------------------------------------------------------------
   // Cell chains: each slot talks only to its two neighbors.
   // ---------------------------------------------------------------------
   genvar i;
   generate
      for (i = 0; i < QUEUE_DEPTH; i++) begin : g_cells
         ready_entry_type r_left;
         logic            r_left_stays;
         ready_entry_type r_right;
         wait_entry_type  w_left;
         logic            w_left_stays;
         wait_entry_type  w_right;

         assign r_occ[i] = fill_type'(i) < ready_fill_ff;
         assign w_occ[i] = fill_type'(i) < waiting_fill_ff;

         if (i == 0) begin : g_first
            // the front slot takes the new entry whenever it does not stay
            assign r_left       = r_ctrl.new_entry;
            assign r_left_stays = 1'b1;
            assign w_left       = w_ctrl.new_entry;
            assign w_left_stays = 1'b1;
         end else begin : g_mid
            assign r_left       = r_entry[i-1];
            assign r_left_stays = r_stays[i-1];
            assign w_left       = w_entry[i-1];
            assign w_left_stays = w_stays[i-1];
         end

         if (i == QUEUE_DEPTH - 1) begin : g_last
            assign r_right = r_entry[i];
            assign w_right = w_entry[i];
         end else begin : g_inner
            assign r_right = r_entry[i+1];
            assign w_right = w_entry[i+1];
         end

         sjfs_ready_cell u_ready_cell (
            .clock       (clock),
            .ctrl        (r_ctrl),
            .occ         (r_occ[i]),
            .left_entry  (r_left),
            .left_stays  (r_left_stays),
            .right_entry (r_right),
            .entry       (r_entry[i]),
            .stays       (r_stays[i])
         );

         sjfs_wait_cell u_wait_cell (
            .clock       (clock),
            .ctrl        (w_ctrl),
            .occ         (w_occ[i]),
            .left_entry  (w_left),
            .left_stays  (w_left_stays),
            .right_entry (w_right),
            .entry       (w_entry[i]),
            .stays       (w_stays[i])
         );
      end
   endgenerate

   // ---------------------------------------------------------------------
   // Command decode
   // ---------------------------------------------------------------------
   assign busy         = (state_ff == ST_TICK);
   assign accept       = start && !busy;
   assign fill_sum     = {1'b0, ready_fill_ff} + {1'b0, waiting_fill_ff};
   assign admit_ok     = fill_sum < (FILL_W+1)'(QUEUE_DEPTH);
   assign block_ok     = (ready_fill_ff != '0);
   assign ready_full   = (ready_fill_ff == fill_type'(QUEUE_DEPTH));
   assign waiting_full = (waiting_fill_ff == fill_type'(QUEUE_DEPTH));

   // during a tick, release the waiting head while its count is zero
   assign wait_release = (state_ff == ST_TICK) && (waiting_fill_ff != '0) &&
                         (w_entry[0].io == 16'd0);

   always_comb begin
      r_ctrl.ins = (accept && (req_command == CMD_ADMIT) && admit_ok) ||
                   (wait_release && !ready_full);
      r_ctrl.pop = accept && (req_command == CMD_BLOCK) && block_ok;
      if (state_ff == ST_TICK) begin
         r_ctrl.new_entry.pid   = w_entry[0].pid;
         r_ctrl.new_entry.burst = w_entry[0].burst;
      end else begin
         r_ctrl.new_entry.pid   = req_process_id;
         r_ctrl.new_entry.burst = req_burst_length;
      end

      // block: ready head drops into the waiting queue with its I/O count
      w_ctrl.ins             = r_ctrl.pop && !waiting_full;
      w_ctrl.pop             = wait_release;
      w_ctrl.dec             = (state_ff == ST_TICK) && !wait_release;
      w_ctrl.new_entry.pid   = r_entry[0].pid;
      w_ctrl.new_entry.burst = r_entry[0].burst;
      w_ctrl.new_entry.io    = req_io_cycles;
   end

   always_comb begin
      ready_fill_in   = ready_fill_ff;
      waiting_fill_in = waiting_fill_ff;
      if (r_ctrl.ins) begin
         ready_fill_in = ready_fill_ff + fill_type'(1);
      end else if (r_ctrl.pop) begin
         ready_fill_in = ready_fill_ff - fill_type'(1);
      end
      if (w_ctrl.ins) begin
         waiting_fill_in = waiting_fill_ff + fill_type'(1);
      end else if (w_ctrl.pop) begin
         waiting_fill_in = waiting_fill_ff - fill_type'(1);
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && (req_command == CMD_TICK)) begin
               state_in = ST_TICK;
            end
         end
         ST_TICK: begin
            if (!wait_release) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // respond once the state reflects the whole command
   assign rsp_valid_in = (accept && (req_command != CMD_TICK)) ||
                         ((state_ff == ST_TICK) && !wait_release);
   assign rej_in       = accept &&
                         (((req_command == CMD_ADMIT) && !admit_ok) ||
                          ((req_command == CMD_BLOCK) && !block_ok));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         ready_fill_ff   <= '0;
         waiting_fill_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         rej_ff          <= 1'b0;
      end else begin
         state_ff        <= state_in;
         ready_fill_ff   <= ready_fill_in;
         waiting_fill_ff <= waiting_fill_in;
         rsp_valid_ff    <= rsp_valid_in;
         rej_ff          <= rej_in;
      end
   end

   // ---------------------------------------------------------------------
   // Response beat, read straight from the queue head and fill counts
   // ---------------------------------------------------------------------
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_rejected        = rej_ff;
   assign rsp_head_valid      = block_ok;
   assign rsp_head_process_id = block_ok ? r_entry[0].pid   : 8'd0;
   assign rsp_head_burst      = block_ok ? r_entry[0].burst : 16'd0;
   assign rsp_ready_count     = 5'(ready_fill_ff);
   assign rsp_waiting_count   = 5'(waiting_fill_ff);

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_tick_goes_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_command == CMD_TICK)) |=> busy)
      else $error("accepted tick did not raise busy");

   a_tick_ends_with_beat: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("tick finished without a response beat");

   a_no_beat_while_busy: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && busy))
      else $error("response beat while a tick is still draining");

   a_capacity: assert property (@(posedge clock) disable iff (reset)
      fill_sum <= (FILL_W+1)'(QUEUE_DEPTH))
      else $error("queues together exceed their capacity");

endmodule

FILE: hdl/sjfs_ready_cell.sv
// ----------------------------------------------------------------------------
// Ready queue cell
// One slot of the burst-sorted ready queue: sorted insert and pop-head shift.
// ----------------------------------------------------------------------------
module sjfs_ready_cell import sjfs_pkg::*; (
   input  logic            clock,
   input  ready_ctrl_type  ctrl,
   input  logic            occ,
   input  ready_entry_type left_entry,
   input  logic            left_stays,
   input  ready_entry_type right_entry,
   output ready_entry_type entry,
   output logic            stays
);

   ready_entry_type entry_ff;
   ready_entry_type entry_in;

   // an occupied slot whose key is not above the new key keeps its place
   assign stays = occ && (entry_ff.burst <= ctrl.new_entry.burst);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = right_entry;
      end else if (ctrl.ins && !stays) begin
         entry_in = left_stays ? ctrl.new_entry : left_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: hdl/sjfs_wait_cell.sv
// ----------------------------------------------------------------------------
// Waiting queue cell
// One slot of the I/O-count-sorted waiting queue: insert, pop, countdown.
// ----------------------------------------------------------------------------
module sjfs_wait_cell import sjfs_pkg::*; (
   input  logic           clock,
   input  wait_ctrl_type  ctrl,
   input  logic           occ,
   input  wait_entry_type left_entry,
   input  logic           left_stays,
   input  wait_entry_type right_entry,
   output wait_entry_type entry,
   output logic           stays
);

   wait_entry_type entry_ff;
   wait_entry_type entry_in;

   assign stays = occ && (entry_ff.io <= ctrl.new_entry.io);

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.pop) begin
         entry_in = right_entry;
      end else if (ctrl.ins && !stays) begin
         entry_in = left_stays ? ctrl.new_entry : left_entry;
      end else if (ctrl.dec && (entry_ff.io != 16'd0)) begin
         entry_in.io = entry_ff.io - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SJF scheduler with I/O wait queue - self-checking testbench
// Drives admit, block, tick and no-op commands through the start/busy port,
// predicts the ready-queue head and both fill levels after every command,
// and checks each strobed response against the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
   import sjfs_pkg::*;

   localparam int CLOCK_HALF    = 5;
   localparam int RESET_CYCLES  = 5;
   localparam int STALL_LIMIT   = 1000;  // cycles with no beat on either side
   localparam int SETTLE_WAIT   = 20;    // cycles to watch for stray strobes
   localparam int RANDOM_BEATS  = 1175;
   localparam int NOISE_BEATS   = 150;
   localparam int PENDING_DEPTH = 8;     // predictions awaiting their beat

   // one predicted response beat
   typedef struct {
      logic        head_valid;
      logic [7:0]  head_pid;
      logic [15:0] head_burst;
      logic [4:0]  ready_count;
      logic [4:0]  waiting_count;
      logic        rejected;
   } sched_status_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_command = CMD_NOP;
   logic [7:0]  req_process_id = '0;
   logic [15:0] req_burst_length = '0;
   logic [15:0] req_io_cycles = '0;
   logic        rsp_valid;
   logic        rsp_head_valid;
   logic [7:0]  rsp_head_process_id;
   logic [15:0] rsp_head_burst;
   logic [4:0]  rsp_ready_count;
   logic [4:0]  rsp_waiting_count;
   logic        rsp_rejected;

   sjf_ready_and_io_wait_scheduler uut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_command         (req_command),
      .req_process_id      (req_process_id),
      .req_burst_length    (req_burst_length),
      .req_io_cycles       (req_io_cycles),
      .rsp_valid           (rsp_valid),
      .rsp_head_valid      (rsp_head_valid),
      .rsp_head_process_id (rsp_head_process_id),
      .rsp_head_burst      (rsp_head_burst),
      .rsp_ready_count     (rsp_ready_count),
      .rsp_waiting_count   (rsp_waiting_count),
      .rsp_rejected        (rsp_rejected)
   );

   // ------------------------------------------------------------------------
   // Scheduler shadow: both sorted queues and their fill levels
   // ------------------------------------------------------------------------
   ready_entry_type  shadow_ready[QUEUE_DEPTH];
   wait_entry_type   shadow_wait[QUEUE_DEPTH];
   int unsigned      ready_used = 0;
   int unsigned      wait_used  = 0;

   // ring of predictions, oldest at pending_head
   sched_status_type pending_status[PENDING_DEPTH];
   int unsigned      pending_head = 0;
   int unsigned      pending_tail = 0;

   int unsigned mismatch_count = 0;
   int unsigned response_beats = 0;
   int unsigned admits_taken   = 0;
   int unsigned blocks_taken   = 0;
   int unsigned ticks_taken    = 0;
   int unsigned nops_taken     = 0;
   int unsigned refusals       = 0;
   int unsigned wakeups        = 0;
   int unsigned most_wakeups   = 0;
   int unsigned stall_cycles   = 0;
   int unsigned beats_left_in_burst = 0;

   function automatic int unsigned pending_count();
      return pending_tail - pending_head;
   endfunction

   // Insert after every entry whose burst is equal or smaller.
   function automatic void ready_place(logic [7:0] pid, logic [15:0] burst);
      int unsigned pos;
      int unsigned k;
      if (ready_used >= QUEUE_DEPTH) return;
      pos = 0;
      while (pos < ready_used && shadow_ready[pos].burst <= burst) pos++;
      for (k = ready_used; k > pos; k--) shadow_ready[k] = shadow_ready[k-1];
      shadow_ready[pos].pid   = pid;
      shadow_ready[pos].burst = burst;
      ready_used++;
   endfunction

   // Same rule for the waiting queue, keyed on the remaining I/O count.
   function automatic void wait_place(ready_entry_type proc, logic [15:0] io);
      int unsigned pos;
      int unsigned k;
      if (wait_used >= QUEUE_DEPTH) return;
      pos = 0;
      while (pos < wait_used && shadow_wait[pos].io <= io) pos++;
      for (k = wait_used; k > pos; k--) shadow_wait[k] = shadow_wait[k-1];
      shadow_wait[pos].pid   = proc.pid;
      shadow_wait[pos].burst = proc.burst;
      shadow_wait[pos].io    = io;
      wait_used++;
   endfunction

   // Wake every zero-count entry from the front, then age the rest.
   function automatic int unsigned io_tick();
      int unsigned woken;
      int unsigned k;
      woken = 0;
      while (woken < wait_used && shadow_wait[woken].io == 16'd0) begin
         ready_place(shadow_wait[woken].pid, shadow_wait[woken].burst);
         woken++;
      end
      for (k = woken; k < wait_used; k++) shadow_wait[k-woken] = shadow_wait[k];
      wait_used -= woken;
      for (k = 0; k < wait_used; k++)
         if (shadow_wait[k].io != 16'd0) shadow_wait[k].io = shadow_wait[k].io - 16'd1;
      return woken;
   endfunction

   // Apply one command to the shadow and return the status it should report.
   function automatic sched_status_type schedule_step(logic [1:0] cmd, logic [7:0] pid,
                                                      logic [15:0] burst, logic [15:0] io);
      sched_status_type status;
      ready_entry_type  head;
      int unsigned      woken;
      int unsigned      k;
      status.rejected = 1'b0;
      case (cmd)
         CMD_TICK: begin
            woken = io_tick();
            ticks_taken++;
            wakeups += woken;
            if (woken > most_wakeups) most_wakeups = woken;
         end
         CMD_ADMIT: begin
            admits_taken++;
            if (ready_used + wait_used >= QUEUE_DEPTH) status.rejected = 1'b1;
            else ready_place(pid, burst);
         end
         CMD_BLOCK: begin
            blocks_taken++;
            if (ready_used == 0) begin
               status.rejected = 1'b1;
            end else begin
               head = shadow_ready[0];
               for (k = 1; k < ready_used; k++) shadow_ready[k-1] = shadow_ready[k];
               ready_used--;
               wait_place(head, io);
            end
         end
         default: nops_taken++;
      endcase
      if (status.rejected) refusals++;
      status.head_valid    = (ready_used > 0);
      status.head_pid      = (ready_used > 0) ? shadow_ready[0].pid   : 8'd0;
      status.head_burst    = (ready_used > 0) ? shadow_ready[0].burst : 16'd0;
      status.ready_count   = ready_used[4:0];
      status.waiting_count = wait_used[4:0];
      return status;
   endfunction

   // ------------------------------------------------------------------------
   // Clock
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   task automatic report_mismatch(string field_name, int unsigned got, int unsigned want);
      $display("mismatch on response beat %0d: %s got %0d, expected %0d",
               response_beats, field_name, got, want);
      mismatch_count++;
   endtask

   // ------------------------------------------------------------------------
   // Response checker and predictor hook. Sample at the rising edge, so the
   // values seen are the ones held through the cycle that the edge ends.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      sched_status_type want;
      if (!reset) begin
         if (rsp_valid) begin
            if (pending_count() == 0) begin
               report_mismatch("strobe with no command pending", 1, 0);
            end else begin
               want = pending_status[pending_head % PENDING_DEPTH];
               pending_head++;
               if (rsp_head_valid !== want.head_valid)
                  report_mismatch("head_valid", rsp_head_valid, want.head_valid);
               if (rsp_head_process_id !== want.head_pid)
                  report_mismatch("head_process_id", rsp_head_process_id, want.head_pid);
               if (rsp_head_burst !== want.head_burst)
                  report_mismatch("head_burst", rsp_head_burst, want.head_burst);
               if (rsp_ready_count !== want.ready_count)
                  report_mismatch("ready_count", rsp_ready_count, want.ready_count);
               if (rsp_waiting_count !== want.waiting_count)
                  report_mismatch("waiting_count", rsp_waiting_count, want.waiting_count);
               if (rsp_rejected !== want.rejected)
                  report_mismatch("rejected", rsp_rejected, want.rejected);
            end
            response_beats++;
         end
         // a request beat is taken on this edge: predict its response now
         if (start && !busy) begin
            if (pending_count() >= PENDING_DEPTH) begin
               report_mismatch("responses outstanding", pending_count(), PENDING_DEPTH - 1);
            end else begin
               pending_status[pending_tail % PENDING_DEPTH] =
                  schedule_step(req_command, req_process_id, req_burst_length, req_io_cycles);
               pending_tail++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Watchdog: end the run when neither side moves a beat for too long.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Sender side
   // ------------------------------------------------------------------------

   // Hold start low, n setting how long; scramble the fields so that the block
   // must ignore them while start is low.
   task automatic idle_sender(int unsigned n);
      repeat (n) begin
         start            <= 1'b0;
         req_command      <= 2'($urandom_range(0, 3));
         req_process_id   <= 8'($urandom_range(0, 255));
         req_burst_length <= 16'($urandom_range(0, 65535));
         req_io_cycles    <= 16'($urandom_range(0, 65535));
         @(posedge clock);
      end
   endtask

   // Bursts of random length; a quarter of them follow on with no gap.
   task automatic pace_sender();
      int unsigned gap;
      if (beats_left_in_burst == 0) begin
         beats_left_in_burst = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         idle_sender(gap);
      end
      beats_left_in_burst--;
   endtask

   // Present one command and hold it until the edge that takes it. Leave
   // start high on return; the next send or idle decides what follows.
   task automatic send_command(logic [1:0] cmd, logic [7:0] pid,
                               logic [15:0] burst, logic [15:0] io);
      pace_sender();
      start            <= 1'b1;
      req_command      <= cmd;
      req_process_id   <= pid;
      req_burst_length <= burst;
      req_io_cycles    <= io;
      do @(posedge clock); while (busy);
   endtask

   // Hold off until every predicted response has come back.
   task automatic wait_for_drain();
      start <= 1'b0;
      do @(posedge clock); while (pending_count() != 0);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Empty-queue cases, key extremes, equal-key ordering and a tick that
   // wakes more than one entry at once.
   task automatic test_ordering_and_refusals();
      send_command(CMD_BLOCK, 8'd3, 16'd9, 16'hFFFF);       // refuse: ready is empty
      send_command(CMD_TICK,  8'hFF, 16'hFFFF, 16'hFFFF);   // tick with nothing waiting
      send_command(CMD_NOP,   8'hFF, 16'hFFFF, 16'hFFFF);
      send_command(CMD_ADMIT, 8'd255, 16'hFFFF, 16'd0);
      send_command(CMD_ADMIT, 8'd0, 16'd0, 16'hFFFF);       // new head
      send_command(CMD_ADMIT, 8'd10, 16'd500, 16'd0);
      send_command(CMD_ADMIT, 8'd11, 16'd500, 16'd0);       // equal burst goes behind
      send_command(CMD_BLOCK, 8'hAA, 16'h5555, 16'd0);
      send_command(CMD_BLOCK, 8'h55, 16'hAAAA, 16'd0);      // equal count goes behind
      send_command(CMD_BLOCK, 8'd0, 16'd0, 16'hFFFF);       // parks for good
      send_command(CMD_TICK,  8'd0, 16'd0, 16'd0);          // two wake at once
      wait_for_drain();
   endtask

   // Fill the two queues together to capacity, then check refusal at full and that a
   // block still goes through because it does not change the total.
   task automatic test_full_capacity();
      int unsigned i;
      for (i = 0; i < QUEUE_DEPTH - 4; i++)
         send_command(CMD_ADMIT, 8'(8'h80 + i), 16'(500 + (i % 3) * 250), 16'hFFFF);
      send_command(CMD_ADMIT, 8'd77, 16'd1, 16'd0);         // refuse: full
      send_command(CMD_BLOCK, 8'd0, 16'd0, 16'd3);
      send_command(CMD_ADMIT, 8'd78, 16'd2, 16'd0);         // still full
      wait_for_drain();
   endtask

   // Mostly short I/O waits so processes cycle between the queues; bursts
   // drawn from a small set half the time to keep ties frequent.
   task automatic test_random_traffic(int unsigned beats);
      int unsigned i;
      int unsigned pick;
      int unsigned io_pick;
      logic [1:0]  cmd;
      logic [15:0] burst;
      logic [15:0] io;
      for (i = 0; i < beats; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 38)      cmd = CMD_ADMIT;
         else if (pick < 66) cmd = CMD_BLOCK;
         else if (pick < 96) cmd = CMD_TICK;
         else                cmd = CMD_NOP;
         burst = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom_range(0, 65535));
         io_pick = $urandom_range(0, 999);
         if (io_pick < 700)      io = 16'($urandom_range(0, 3));
         else if (io_pick < 995) io = 16'($urandom_range(4, 40));
         else                    io = 16'($urandom_range(0, 65535));
         send_command(cmd, 8'($urandom_range(0, 255)), burst, io);
         if ($urandom_range(0, 99) == 0) wait_for_drain();
      end
      wait_for_drain();
   endtask

   // Unshaped commands and full-range fields.
   task automatic test_noise(int unsigned beats);
      repeat (beats)
         send_command(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                      16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
      wait_for_drain();
   endtask

   // ------------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------------
   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_ordering_and_refusals();
      test_full_capacity();
      test_random_traffic(RANDOM_BEATS);
      test_noise(NOISE_BEATS);

      // drop start and watch a while longer for stray strobes
      idle_sender(SETTLE_WAIT);
      if (pending_count() != 0)
         report_mismatch("responses still outstanding", 0, pending_count());

      $display("covered: %0d admits, %0d blocks, %0d ticks, %0d no-ops, %0d refused",
               admits_taken, blocks_taken, ticks_taken, nops_taken, refusals);
      $display("covered: %0d wakeups, up to %0d in one tick, %0d responses checked",
               wakeups, most_wakeups, response_beats);
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
